### rtl/div128_pkg.sv
// Package of widths shared by the divider cells and the divider top level.
`timescale 1ns / 1ps

package div128_pkg;

    localparam int FIELD_BITS = 64;
    localparam int S_TDATA_BITS = 2 * FIELD_BITS;
    localparam int M_TDATA_BITS = FIELD_BITS;
    localparam int M_TUSER_BITS = 1;

endpackage

### rtl/div128_cell.sv
// One restoring shift-and-subtract division step held in its own pipeline registers.
`timescale 1ns / 1ps

module div128_cell #(
    parameter int WORD_BITS = div128_pkg::FIELD_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic [WORD_BITS-1:0] rem_in,
    input  logic [WORD_BITS-1:0] den_in,
    input  logic [WORD_BITS-1:0] dvd_in,
    input  logic [WORD_BITS-1:0] quo_in,
    output logic                 valid_out,
    output logic [WORD_BITS-1:0] rem_out,
    output logic [WORD_BITS-1:0] den_out,
    output logic [WORD_BITS-1:0] dvd_out,
    output logic [WORD_BITS-1:0] quo_out
);

    logic                 valid_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] den_reg;
    logic [WORD_BITS-1:0] dvd_reg;
    logic [WORD_BITS-1:0] quo_reg;

    logic [WORD_BITS-1:0] rem_next;
    logic [WORD_BITS-1:0] dvd_next;
    logic [WORD_BITS-1:0] quo_next;
    logic [WORD_BITS-1:0] shifted;
    logic [WORD_BITS-1:0] diff;
    logic                 take;

    // The bit shifted out of the remainder counts as weight 2^WORD_BITS, so it forces a subtract.
    always_comb
    begin
        shifted  = {rem_in[WORD_BITS-2:0], dvd_in[WORD_BITS-1]};
        diff     = shifted - den_in;
        take     = rem_in[WORD_BITS-1] || (shifted >= den_in);
        rem_next = take ? diff : shifted;
        quo_next = {quo_in[WORD_BITS-2:0], take};
        dvd_next = {dvd_in[WORD_BITS-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            dvd_reg <= dvd_next;
            quo_reg <= quo_next;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign den_out   = den_reg;
    assign dvd_out   = dvd_reg;
    assign quo_out   = quo_reg;

endmodule

### rtl/divide_128_by_64_low_quotient_unit.sv
// Top level of the pipelined 2W-by-W divider that returns the low quotient word.
// Throughput: one transaction per cycle while the output is not stalled, through a chain of 2*WORD_BITS division cells.
// A stall on the output side freezes the whole chain until the result is taken.
// Reset clears all valid flags asynchronously; the data registers are not reset.
`timescale 1ns / 1ps

module divide_128_by_64_low_quotient_unit #(
    parameter int WORD_BITS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // value_high [63:0], divisor [127:64]
    input  logic [div128_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // quotient_low [63:0]
    output logic [div128_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
    // divide_by_zero [0]
    output logic [div128_pkg::M_TUSER_BITS-1:0] m_axis_tuser
);

    localparam int STAGES = 2 * WORD_BITS;

    logic                 en;
    logic                 valid_w [0:STAGES];
    logic [WORD_BITS-1:0] rem_w   [0:STAGES];
    logic [WORD_BITS-1:0] den_w   [0:STAGES];
    logic [WORD_BITS-1:0] dvd_w   [0:STAGES];
    logic [WORD_BITS-1:0] quo_w   [0:STAGES];

    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] quo_reg;
    logic                 dz_reg;
    logic [WORD_BITS-1:0] quo_next;
    logic                 dz_next;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    assign valid_w[0] = s_axis_tvalid;
    assign rem_w[0]   = '0;
    assign dvd_w[0]   = s_axis_tdata[WORD_BITS-1:0];
    assign den_w[0]   = s_axis_tdata[div128_pkg::FIELD_BITS +: WORD_BITS];
    assign quo_w[0]   = '0;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        div128_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (valid_w[i]),
            .rem_in    (rem_w[i]),
            .den_in    (den_w[i]),
            .dvd_in    (dvd_w[i]),
            .quo_in    (quo_w[i]),
            .valid_out (valid_w[i+1]),
            .rem_out   (rem_w[i+1]),
            .den_out   (den_w[i+1]),
            .dvd_out   (dvd_w[i+1]),
            .quo_out   (quo_w[i+1])
        );
    end

    // A zero divisor makes every step subtract, so the quotient is replaced by zero here.
    always_comb
    begin
        dz_next  = (den_w[STAGES] == '0);
        quo_next = dz_next ? '0 : quo_w[STAGES];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_w[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
            dz_reg  <= dz_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = div128_pkg::M_TDATA_BITS'(quo_reg);
    assign m_axis_tuser  = div128_pkg::M_TUSER_BITS'(dz_reg);

    a_dz_zero_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("Divide-by-zero result carries a non-zero quotient.");

    a_quotient_fits: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata >> WORD_BITS) == '0))
        else $error("Quotient exceeds the configured word width.");

    a_chain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(valid_w[STAGES]) && $stable(quo_w[STAGES])))
        else $error("Division chain advanced while the output was stalled.");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(valid_w[STAGES]))
        else $error("Result appeared without a transaction leaving the chain.");

endmodule
